// ===== src/skpd_pkg.sv =====
// skpd_pkg: shared types, register codes, exp table and back-end states
// for the SimCC keypoint decoder. No dependencies.
package skpd_pkg;

  localparam int unsigned SUM_ONE   = 65536;
  localparam int unsigned DIV_STEPS = 9;
  localparam logic [20:0] POS_INVALID = 21'h1FFFF0;
  localparam logic signed [20:0] POS_MAX = 21'sh0FFFFF;
  localparam logic signed [20:0] POS_MIN = 21'sh100000;

  typedef enum logic [2:0] {
    REG_SOFTMAX  = 3'd0,
    REG_SCALE_X  = 3'd1,
    REG_SCALE_Y  = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        softmax_enable;
    logic [15:0] scale_x;
    logic [15:0] scale_y;
    logic [9:0]  offset_x;
    logic [9:0]  offset_y;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_MEM,
    B_MUL,
    B_OUT
  } back_state_t;

  // exp(-900*k/256) in Q1.16
  function automatic logic [16:0] exp_lut(input logic [16:0] k);
    logic [16:0] e;
    case (k)
      17'd0:   e = 17'd65536;
      17'd1:   e = 17'd1948;
      17'd2:   e = 17'd58;
      17'd3:   e = 17'd2;
      default: e = 17'd0;
    endcase
    return e;
  endfunction

endpackage

// ===== src/skpd_front.sv =====
// skpd_front: accepts heatmap bins, tracks row maximum, argmax and the
// online exp sum, and pushes one record per row end. Uses skpd_pkg.
module skpd_front
  import skpd_pkg::*;
#(
  parameter int MAX_KEYPOINTS = 256,
  parameter int MAX_BINS      = 1024,
  parameter int BW            = 10,
  parameter int KW            = 8,
  parameter int RW            = 1 + 16 + BW + 32 + 1 + KW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_axis,
  input  logic signed [15:0]   in_heat_value,
  input  logic                 in_row_end,
  input  logic                 in_set_end,
  output logic                 q_push,
  output logic [RW-1:0]        q_data,
  input  logic                 q_full
);

  localparam int BCW = $clog2(MAX_BINS + 1);

  logic                pend_r;
  logic                axis_r, rend_r, send_r;
  logic signed [15:0]  v_r;
  logic [BCW-1:0]      bcnt_r, bcnt_nxt;
  logic signed [15:0]  max_r, max_nxt;
  logic [BW-1:0]       arg_r, arg_nxt;
  logic [31:0]         sum_r, sum_nxt;
  logic [KW-1:0]       row_r, row_nxt;
  logic                fire;
  logic [BW-1:0]       idx;
  logic signed [16:0]  diff;
  logic [16:0]         e;
  logic [42:0]         prod;
  logic [32:0]         acc;

  assign in_stall = pend_r;
  assign fire     = pend_r && !(rend_r && q_full);
  assign q_push   = fire && rend_r;

  always_comb begin
    idx  = (bcnt_r >= BCW'(MAX_BINS)) ? BW'(MAX_BINS - 1) : bcnt_r[BW-1:0];
    diff = 17'(v_r) - 17'(max_r);
    e    = exp_lut((diff > 0) ? 17'(diff) : 17'(-diff));
    prod = 43'(sum_r) * 43'(e[10:0]);
    acc  = 33'(sum_r) + 33'(e);
    max_nxt = max_r;
    arg_nxt = arg_r;
    sum_nxt = sum_r;
    if (bcnt_r == '0) begin
      max_nxt = v_r;
      arg_nxt = '0;
      sum_nxt = 32'(SUM_ONE);
    end else if (diff > 0) begin
      max_nxt = v_r;
      arg_nxt = idx;
      sum_nxt = 32'(prod[42:16]) + 32'(SUM_ONE);
    end else begin
      sum_nxt = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
    end
    bcnt_nxt = (bcnt_r < BCW'(MAX_BINS)) ? bcnt_r + 1'b1 : bcnt_r;
    row_nxt  = (send_r || row_r == KW'(MAX_KEYPOINTS - 1)) ? '0 : row_r + 1'b1;
    if (rend_r) bcnt_nxt = '0;
    q_data = {axis_r, max_nxt, arg_nxt, sum_nxt, send_r, row_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      bcnt_r <= '0;
      row_r  <= '0;
      max_r  <= '0;
      arg_r  <= '0;
      sum_r  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        pend_r <= 1'b1;
        axis_r <= in_axis;
        v_r    <= in_heat_value;
        rend_r <= in_row_end | in_set_end;
        send_r <= in_set_end;
      end else if (fire) begin
        pend_r <= 1'b0;
      end
      if (fire) begin
        bcnt_r <= bcnt_nxt;
        max_r  <= max_nxt;
        arg_r  <= arg_nxt;
        sum_r  <= sum_nxt;
        if (rend_r) row_r <= row_nxt;
      end
    end
  end

endmodule

// ===== src/skpd_queue.sv =====
// skpd_queue: two-entry row record queue between front and back end.
// No dependencies.
module skpd_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] ent_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== src/skpd_back.sv =====
// skpd_back: per-row scoring (iterative divider), x row store, position
// arithmetic and output register. Uses skpd_pkg.
module skpd_back
  import skpd_pkg::*;
#(
  parameter int MAX_KEYPOINTS = 256,
  parameter int BW            = 10,
  parameter int KW            = 8,
  parameter int RW            = 1 + 16 + BW + 32 + 1 + KW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic [RW-1:0]        q_data,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_keypoint_index,
  output logic signed [20:0]   out_pos_x,
  output logic signed [20:0]   out_pos_y,
  output logic signed [15:0]   out_score,
  output logic                 out_last
);

  localparam int DW = ((BW > 10) ? BW : 10) + 1;
  localparam int PW = DW + 17;

  back_state_t state_r, state_nxt;

  logic                axis_r, last_r;
  logic signed [15:0]  score_r;
  logic [BW-1:0]       bin_r;
  logic [31:0]         div_r;
  logic [KW-1:0]       slot_r;
  logic [32:0]         rem_r;
  logic [8:0]          dlow_r;
  logic [3:0]          dcnt_r;
  logic [32:0]         trial;
  logic                tge;
  logic [32:0]         dvd;

  logic [BW-1:0]       xbin_mem [MAX_KEYPOINTS];
  logic signed [15:0]  xscore_mem [MAX_KEYPOINTS];
  logic [BW-1:0]       xbin_q;
  logic signed [15:0]  xscore_q;

  logic signed [PW-1:0] px_r, py_r;
  logic signed [15:0]   smin_r;
  logic signed [15:0]   smin;
  logic                 load;

  logic                 ov_r;
  logic [7:0]           kp_r;
  logic signed [20:0]   ox_r, oy_r;
  logic signed [15:0]   os_r;
  logic                 ol_r;

  function automatic logic signed [20:0] fin_pos(input logic signed [PW-1:0] p);
    logic signed [PW:0]   t;
    logic signed [PW-5:0] s;
    t = (PW+1)'(p) + (PW+1)'(16);
    s = (PW-4)'(t >>> 5);
    if (s > (PW-4)'(POS_MAX))      return POS_MAX;
    else if (s < (PW-4)'(POS_MIN)) return POS_MIN;
    else                           return 21'(s);
  endfunction

  assign q_pop = (state_r == B_IDLE) && !q_empty;
  assign dvd   = (33'd1 << 24) + 33'(q_data[KW+1 +: 32] >> 1);
  assign trial = {rem_r[31:0], dlow_r[8]};
  assign tge   = trial >= 33'(div_r);
  assign smin  = (xscore_q < score_r) ? xscore_q : score_r;
  assign load  = (state_r == B_OUT) && (!ov_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_empty) state_nxt = cfg.softmax_enable ? B_DIV : B_MEM;
      B_DIV:  if (dcnt_r == 4'(DIV_STEPS - 1)) state_nxt = B_MEM;
      B_MEM:  state_nxt = axis_r ? B_MUL : B_IDLE;
      B_MUL:  state_nxt = B_OUT;
      B_OUT:  if (load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      {axis_r, score_r, bin_r, div_r, last_r, slot_r} <= q_data;
      rem_r  <= 33'(dvd[32:9]);
      dlow_r <= dvd[8:0];
      dcnt_r <= '0;
    end
    if (state_r == B_DIV) begin
      rem_r   <= tge ? trial - 33'(div_r) : trial;
      dlow_r  <= {dlow_r[7:0], 1'b0};
      dcnt_r  <= dcnt_r + 1'b1;
      score_r <= {score_r[14:0], tge};
      if (dcnt_r == 4'd0) score_r <= 16'(tge);
    end
    if (state_r == B_MEM && !axis_r) begin
      xbin_mem[slot_r]   <= bin_r;
      xscore_mem[slot_r] <= score_r;
    end
    xbin_q   <= xbin_mem[slot_r];
    xscore_q <= xscore_mem[slot_r];
    if (state_r == B_MUL) begin
      smin_r <= smin;
      px_r <= PW'($signed(DW'({1'b0, xbin_q})) - $signed(DW'({1'b0, cfg.offset_x})))
              * PW'($signed({1'b0, cfg.scale_x}));
      py_r <= PW'($signed(DW'({1'b0, bin_r})) - $signed(DW'({1'b0, cfg.offset_y})))
              * PW'($signed({1'b0, cfg.scale_y}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (load) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
    if (load) begin
      kp_r <= 8'(slot_r);
      os_r <= smin_r;
      ol_r <= last_r;
      ox_r <= (smin_r <= 0) ? POS_INVALID : fin_pos(px_r);
      oy_r <= (smin_r <= 0) ? POS_INVALID : fin_pos(py_r);
    end
  end

  assign out_valid          = ov_r;
  assign out_keypoint_index = kp_r;
  assign out_pos_x          = ox_r;
  assign out_pos_y          = oy_r;
  assign out_score          = os_r;
  assign out_last           = ol_r;

`ifndef SYNTHESIS
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_DIV |-> dcnt_r < 4'(DIV_STEPS))
    else $error("divider step count overrun");
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV && dcnt_r == 4'(DIV_STEPS - 1)) |=>
      (score_r >= 0 && score_r <= 16'sd256))
    else $error("softmax score out of range");
  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("output register not loaded");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r != B_IDLE)
    else $error("popped record not processed");
`endif

endmodule

// ===== src/simcc_keypoint_decoder.sv =====
// simcc_keypoint_decoder: top level, APB register file plus front end,
// record queue and back end. Uses skpd_pkg, skpd_front, skpd_queue, skpd_back.
//
// Input channel (in_*): one heatmap bin per item, all x rows then all y
// rows, one row per keypoint; row_end marks a row's last bin, set_end the
// last bin of an axis. A bin is taken on in_valid with in_stall low.
// Each bin is registered first and then used for the running
// max / exp-sum update, a loop through a 32x11 multiplier.
// Output channel (out_*): one keypoint item at the end of every y row,
// held in an output register until taken (out_valid high, out_stall low).
// Row ends go through a two-entry queue to the back end, which takes
// an x row through states IDLE and MEM and a y row through IDLE, MEM,
// MUL and OUT, plus a one-bit-per-cycle divider (DIV) in softmax mode.
// Short rows back-pressure through in_stall once the queue fills; an
// output stall holds the back end, then the queue, then the input.
// Registers (APB, 4-byte spacing): softmax_enable, scale_x, scale_y,
// offset_x, offset_y; write only while idle. Synchronous reset clears
// control state and restores register defaults; the x row store is not
// cleared, and a y row reads the x row of the same keypoint.
module simcc_keypoint_decoder
  import skpd_pkg::*;
#(
  parameter int MAX_KEYPOINTS = 256,
  parameter int MAX_BINS      = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_axis,
  input  logic signed [15:0]  in_heat_value,
  input  logic                in_row_end,
  input  logic                in_set_end,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_keypoint_index,
  output logic signed [20:0]  out_pos_x,
  output logic signed [20:0]  out_pos_y,
  output logic signed [15:0]  out_score,
  output logic                out_last
);

  localparam int BW = $clog2(MAX_BINS);
  localparam int KW = (MAX_KEYPOINTS > 1) ? $clog2(MAX_KEYPOINTS) : 1;
  localparam int RW = 1 + 16 + BW + 32 + 1 + KW;

  cfg_t          cfg_r;
  reg_idx_t      ridx;
  logic          q_push, q_pop, q_full, q_empty;
  logic [RW-1:0] q_wdata, q_rdata;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{softmax_enable: 1'b0, scale_x: 16'd256, scale_y: 16'd256,
                 offset_x: 10'd0, offset_y: 10'd0};
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_SOFTMAX:  cfg_r.softmax_enable <= pwdata[0];
        REG_SCALE_X:  cfg_r.scale_x        <= pwdata[15:0];
        REG_SCALE_Y:  cfg_r.scale_y        <= pwdata[15:0];
        REG_OFFSET_X: cfg_r.offset_x       <= pwdata[9:0];
        REG_OFFSET_Y: cfg_r.offset_y       <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_SOFTMAX:  prdata = 32'(cfg_r.softmax_enable);
      REG_SCALE_X:  prdata = 32'(cfg_r.scale_x);
      REG_SCALE_Y:  prdata = 32'(cfg_r.scale_y);
      REG_OFFSET_X: prdata = 32'(cfg_r.offset_x);
      REG_OFFSET_Y: prdata = 32'(cfg_r.offset_y);
      default:      prdata = 32'd0;
    endcase
  end

  skpd_front #(.MAX_KEYPOINTS(MAX_KEYPOINTS), .MAX_BINS(MAX_BINS),
               .BW(BW), .KW(KW), .RW(RW)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_axis, .in_heat_value,
    .in_row_end, .in_set_end, .q_push, .q_data(q_wdata), .q_full
  );

  skpd_queue #(.W(RW)) u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .full(q_full), .empty(q_empty)
  );

  skpd_back #(.MAX_KEYPOINTS(MAX_KEYPOINTS), .BW(BW), .KW(KW), .RW(RW)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_data(q_rdata), .q_empty, .q_pop,
    .out_valid, .out_stall, .out_keypoint_index, .out_pos_x, .out_pos_y,
    .out_score, .out_last
  );

endmodule

// ===== bench/simcc_keypoint_decoder_tb.sv =====
// Testbench for simcc_keypoint_decoder: streams x and y heatmap rows,
// predicts every keypoint item in a scoreboard class and checks each result.
// Depends on skpd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module simcc_keypoint_decoder_tb
  import skpd_pkg::*;
();

  typedef struct packed {
    logic [7:0]         idx;
    logic signed [20:0] px;
    logic signed [20:0] py;
    logic signed [15:0] score;
    logic               last;
  } keypoint_t;

  class keypoint_scoreboard;
    bit                 sm_en;
    bit [15:0]          scl_x, scl_y;
    bit [9:0]           off_x, off_y;
    bit [9:0]           x_bin[256];
    logic signed [15:0] x_score[256];
    bit                 x_seen[256];
    logic signed [15:0] peak;
    bit [9:0]           peak_bin;
    int unsigned        bin_cnt;
    bit [31:0]          sum;
    int unsigned        row;
    keypoint_t          pending[$];
    int                 errors;

    function new();
      sm_en = 0; scl_x = 256; scl_y = 256; off_x = 0; off_y = 0;
      peak = 0; peak_bin = 0; bin_cnt = 0; sum = 0; row = 0; errors = 0;
      foreach (x_seen[i]) x_seen[i] = 0;
    endfunction

    function void set_reg(reg_idx_t r, bit [31:0] d);
      case (r)
        REG_SOFTMAX:  sm_en = d[0];
        REG_SCALE_X:  scl_x = d[15:0];
        REG_SCALE_Y:  scl_y = d[15:0];
        REG_OFFSET_X: off_x = d[9:0];
        REG_OFFSET_Y: off_y = d[9:0];
        default: ;
      endcase
    endfunction

    function longint unsigned exp_weight(int d);
      case (d)
        0: return 65536;
        1: return 1948;
        2: return 58;
        3: return 2;
        default: return 0;
      endcase
    endfunction

    function logic signed [20:0] place(bit [9:0] b, bit [9:0] off, bit [15:0] scl);
      longint t;
      t = ((longint'(b) - longint'(off)) * longint'(scl) + 16) >>> 5;
      if (t > 1048575) t = 1048575;
      if (t < -1048576) t = -1048576;
      return 21'(t);
    endfunction

    function void note_input(bit axis, logic signed [15:0] v, bit re, bit se);
      longint unsigned acc;
      logic signed [15:0] rs, s;
      int unsigned slot;
      keypoint_t k;
      if (bin_cnt == 0) begin
        peak = v; peak_bin = 0; sum = 32'd65536;
      end else if (v > peak) begin
        acc = ((longint'(sum) * exp_weight(int'(v) - int'(peak))) >> 16) + 65536;
        sum = acc > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : acc[31:0];
        peak = v;
        peak_bin = bin_cnt < 1024 ? 10'(bin_cnt) : 10'd1023;
      end else begin
        acc = longint'(sum) + exp_weight(int'(peak) - int'(v));
        sum = acc > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : acc[31:0];
      end
      if (bin_cnt < 1024) bin_cnt++;
      if (!(re || se)) return;
      if (sm_en) begin
        acc = ((64'd1 << 24) + (sum >> 1)) / sum;
        rs = 16'(acc);
      end else
        rs = peak;
      bin_cnt = 0;
      slot = row;
      row = (se || slot == 255) ? 0 : slot + 1;
      if (!axis) begin
        x_bin[slot] = peak_bin; x_score[slot] = rs; x_seen[slot] = 1;
        return;
      end
      s = x_score[slot] < rs ? x_score[slot] : rs;
      k.idx = 8'(slot); k.score = s; k.last = se;
      if (s <= 0) begin
        k.px = POS_INVALID; k.py = POS_INVALID;
      end else begin
        k.px = place(x_bin[slot], off_x, scl_x);
        k.py = place(peak_bin, off_y, scl_y);
      end
      pending.insert(pending.size(), k);
    endfunction

    function void check_result(keypoint_t got);
      keypoint_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected keypoint item idx=%0d", got.idx);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp idx=%0d x=%0d y=%0d s=%0d l=%0b",
                    " got idx=%0d x=%0d y=%0d s=%0d l=%0b"},
                   e.idx, e.px, e.py, e.score, e.last,
                   got.idx, got.px, got.py, got.score, got.last);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_stall, in_axis, in_row_end, in_set_end;
  logic signed [15:0] in_heat_value;
  logic out_valid, out_stall, out_last;
  logic [7:0] out_keypoint_index;
  logic signed [20:0] out_pos_x, out_pos_y;
  logic signed [15:0] out_score;

  keypoint_scoreboard sb;
  bit quiet;
  int idle_cnt;

  simcc_keypoint_decoder u_dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_axis, .in_heat_value, .in_row_end, .in_set_end,
    .out_valid, .out_stall, .out_keypoint_index, .out_pos_x, .out_pos_y,
    .out_score, .out_last
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    keypoint_t g;
    if (rst_n && out_valid && !out_stall) begin
      g.idx = out_keypoint_index; g.px = out_pos_x; g.py = out_pos_y;
      g.score = out_score; g.last = out_last;
      sb.check_result(g);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= 4000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send_bin(bit axis, logic signed [15:0] v, bit re, bit se);
    if ((re || se) && axis && !sb.x_seen[sb.row]) axis = 0;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1;
    in_axis <= axis;
    in_heat_value <= v;
    in_row_end <= re;
    in_set_end <= se;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(axis, v, re, se);
  endtask

  task automatic send_row(bit axis, int len, bit se);
    logic signed [15:0] base, v;
    bit a, re;
    base = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    for (int i = 0; i < len; i++) begin
      v = $urandom_range(0, 5) == 0 ? 16'($urandom) : base - 16'($urandom_range(0, 5));
      a = $urandom_range(0, 9) == 0 ? !axis : axis;
      re = i == len - 1;
      if (re && se && $urandom_range(0, 3) == 0) re = 0;
      send_bin(i == len - 1 ? axis : a, v, re, se && i == len - 1);
    end
  endtask

  task automatic send_set(int n, int maxlen);
    for (int ax = 0; ax < 2; ax++)
      for (int k = 0; k < n; k++)
        send_row(ax[0], $urandom_range(1, maxlen), k == n - 1);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, bit [31:0] d);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {r, 2'b00}; pwdata <= d;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    sb.set_reg(r, d);
    @(negedge clk);
    psel <= 0; penable <= 0;
  endtask

  task automatic configure(bit sm, bit [15:0] sx, bit [15:0] sy, bit [9:0] ox, bit [9:0] oy);
    wait_idle();
    write_reg(REG_SOFTMAX, 32'(sm));
    write_reg(REG_SCALE_X, 32'(sx));
    write_reg(REG_SCALE_Y, 32'(sy));
    write_reg(REG_OFFSET_X, 32'(ox));
    write_reg(REG_OFFSET_Y, 32'(oy));
  endtask

  function automatic bit [15:0] pick_scale();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
    return 16'($urandom_range(64, 1024));
  endfunction

  function automatic bit [9:0] pick_offset();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 10'h3FF : 10'h0;
    return 10'($urandom_range(0, 20));
  endfunction

  task automatic directed_set();
    send_bin(0, 16'sh7FFF, 0, 0);
    send_bin(0, -16'sh8000, 0, 0);
    send_bin(0, 16'sh7FFF, 1, 0);
    send_bin(0, -16'sh8000, 0, 1);
    send_bin(1, 16'sd0, 0, 0);
    send_bin(1, 16'sd1, 0, 0);
    send_bin(1, 16'sd3, 0, 0);
    send_bin(1, 16'sd6, 0, 0);
    send_bin(1, 16'sd100, 1, 0);
    send_bin(0, 16'sd50, 0, 0);
    send_bin(1, 16'sd40, 1, 1);
  endtask

  initial begin
    sb = new();
    quiet = 0;
    rst_n = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; in_axis = 0; in_heat_value = '0; in_row_end = 0; in_set_end = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    directed_set();
    configure(1, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF);
    directed_set();
    configure(0, 16'h0, 16'h0, 10'h0, 10'h0);
    directed_set();

    for (int p = 0; p < 6; p++) begin
      configure(p[0], pick_scale(), pick_scale(), pick_offset(), pick_offset());
      quiet = p == 5;
      repeat (3) send_set($urandom_range(1, 5), 8);
    end

    wait_idle();
    repeat (30) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
